>>> src/btp_pkg.sv
// Shared types and constants for the BER TLV stream parser.
package btp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_VAL  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_TAG   = 2'd0;
  localparam logic [1:0] ERR_INDEF = 2'd1;
  localparam logic [1:0] ERR_WIDE  = 2'd2;
  localparam logic [1:0] ERR_TRUNC = 2'd3;

  // Identifier and length octet fields
  localparam logic [4:0] TAG_LONG_FORM = 5'h1F;
  localparam int         MORE_BIT      = 7;
  localparam int         ACCUM_W       = 32;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [13:0] tag_number;
    logic [31:0] content_length;
    logic [7:0]  value_byte;
    logic        value_end;
    logic [1:0]  error_code;
    logic        last_of_run;
  } result_t;

  // One queue entry: everything a single input byte causes
  typedef struct packed {
    logic    has_primary;
    result_t primary;
    logic    has_tail;
    logic    tail_err;
  } entry_t;

endpackage

>>> src/btp_front.sv
// Front end: decodes identifier, length and content bytes into queue entries.
module btp_front #(
  parameter int MAX_LEN_OCTETS = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  btp_pkg::item_t  item,
  output logic            wr,
  output btp_pkg::entry_t entry
);

  localparam int LW = $clog2(MAX_LEN_OCTETS + 1);

  localparam logic [2:0] PH_ID   = 3'd0;
  localparam logic [2:0] PH_TAG1 = 3'd1;
  localparam logic [2:0] PH_TAG2 = 3'd2;
  localparam logic [2:0] PH_LEN0 = 3'd3;
  localparam logic [2:0] PH_LENN = 3'd4;
  localparam logic [2:0] PH_VAL  = 3'd5;

  logic [2:0]  phase, phase_next;
  logic        flushing, flushing_next;
  logic [1:0]  held_class, held_class_next;
  logic        held_constructed, held_constructed_next;
  logic [13:0] held_tag, held_tag_next;
  logic [LW-1:0] len_left, len_left_next;
  logic [btp_pkg::ACCUM_W-1:0] length_accum, length_accum_next;
  logic [31:0] content_left, content_left_next;

  // Decode one byte
  always_comb begin
    logic [7:0]  b;
    logic        eob;
    logic        prim_v;
    logic        tail_v;
    logic        tail_err;
    btp_pkg::result_t prim;
    logic [6:0]  cnt;
    logic [btp_pkg::ACCUM_W-1:0] acc_new;
    logic [LW-1:0] left_dec;
    logic [31:0] cl_dec;

    b        = item.in_byte;
    eob      = item.end_of_buffer;
    prim_v   = 1'b0;
    tail_v   = 1'b0;
    tail_err = 1'b0;
    prim     = '0;
    cnt      = b[6:0];
    acc_new  = {length_accum[btp_pkg::ACCUM_W-9:0], b};
    left_dec = (len_left != '0) ? len_left - 1'b1 : len_left;
    cl_dec   = (content_left != '0) ? content_left - 32'd1 : content_left;

    phase_next            = phase;
    flushing_next         = flushing;
    held_class_next       = held_class;
    held_constructed_next = held_constructed;
    held_tag_next         = held_tag;
    len_left_next         = len_left;
    length_accum_next     = length_accum;
    content_left_next     = content_left;

    if (flushing) begin
      // Drop bytes until the buffer ends
      if (eob) begin
        flushing_next = 1'b0;
        phase_next    = PH_ID;
      end
    end else begin
      case (phase)
        PH_ID: begin
          held_class_next       = b[7:6];
          held_constructed_next = b[5];
          if (b[4:0] == btp_pkg::TAG_LONG_FORM) begin
            held_tag_next = '0;
            phase_next    = PH_TAG1;
          end else begin
            held_tag_next = {9'd0, b[4:0]};
            phase_next    = PH_LEN0;
          end
        end
        PH_TAG1: begin
          if (b[btp_pkg::MORE_BIT]) begin
            held_tag_next = {b[6:0], 7'd0};
            phase_next    = PH_TAG2;
          end else begin
            held_tag_next = {6'd0, b};
            phase_next    = PH_LEN0;
          end
        end
        PH_TAG2: begin
          if (b[btp_pkg::MORE_BIT]) begin
            prim_v          = 1'b1;
            prim.kind       = btp_pkg::KIND_ERR;
            prim.error_code = btp_pkg::ERR_TAG;
            flushing_next   = 1'b1;
            phase_next      = PH_ID;
          end else begin
            held_tag_next = held_tag | {7'd0, b[6:0]};
            phase_next    = PH_LEN0;
          end
        end
        PH_LEN0: begin
          if (!b[btp_pkg::MORE_BIT]) begin
            prim_v              = 1'b1;
            prim.kind           = btp_pkg::KIND_HDR;
            prim.tag_class      = held_class;
            prim.constructed    = held_constructed;
            prim.tag_number     = held_tag;
            prim.content_length = {24'd0, b};
            content_left_next   = {24'd0, b};
            phase_next          = (b == 8'd0) ? PH_ID : PH_VAL;
          end else if (cnt == 7'd0) begin
            prim_v          = 1'b1;
            prim.kind       = btp_pkg::KIND_ERR;
            prim.error_code = btp_pkg::ERR_INDEF;
            flushing_next   = 1'b1;
            phase_next      = PH_ID;
          end else if (cnt > 7'(MAX_LEN_OCTETS)) begin
            prim_v          = 1'b1;
            prim.kind       = btp_pkg::KIND_ERR;
            prim.error_code = btp_pkg::ERR_WIDE;
            flushing_next   = 1'b1;
            phase_next      = PH_ID;
          end else begin
            length_accum_next = '0;
            len_left_next     = LW'(cnt);
            phase_next        = PH_LENN;
          end
        end
        PH_LENN: begin
          // Shift in one big-endian length byte
          length_accum_next = acc_new;
          len_left_next     = left_dec;
          if (left_dec == '0) begin
            prim_v              = 1'b1;
            prim.kind           = btp_pkg::KIND_HDR;
            prim.tag_class      = held_class;
            prim.constructed    = held_constructed;
            prim.tag_number     = held_tag;
            prim.content_length = acc_new;
            content_left_next   = acc_new;
            phase_next          = (acc_new == '0) ? PH_ID : PH_VAL;
          end
        end
        PH_VAL: begin
          prim_v            = 1'b1;
          prim.kind         = btp_pkg::KIND_VAL;
          prim.value_byte   = b;
          content_left_next = cl_dec;
          if (cl_dec == 32'd0) begin
            prim.value_end = 1'b1;
            phase_next     = PH_ID;
          end
        end
        default: begin
          phase_next = PH_ID;
        end
      endcase

      // Close out the buffer
      if (eob) begin
        if (flushing_next) begin
          flushing_next = 1'b0;
        end else begin
          tail_v   = 1'b1;
          tail_err = (phase_next != PH_ID);
        end
        phase_next = PH_ID;
      end
    end

    wr                = accept && (prim_v || tail_v);
    entry.has_primary = prim_v;
    entry.primary     = prim;
    entry.has_tail    = tail_v;
    entry.tail_err    = tail_err;
  end

  // Hold decode state, advance on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ID;
      flushing     <= 1'b0;
      len_left     <= '0;
      content_left <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      flushing     <= flushing_next;
      len_left     <= len_left_next;
      content_left <= content_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_class       <= held_class_next;
      held_constructed <= held_constructed_next;
      held_tag         <= held_tag_next;
      length_accum     <= length_accum_next;
    end
  end

endmodule

>>> src/btp_queue.sv
// Small entry queue between the decoder and the result stage.
module btp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  btp_pkg::entry_t wr_entry,
  input  logic            rd,
  output btp_pkg::entry_t rd_entry,
  output logic            full,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  btp_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/btp_back.sv
// Result stage: splits queue entries into single results for the consumer.
module btp_back (
  input  logic              clk,
  input  logic              rst,
  input  btp_pkg::entry_t   q_entry,
  input  logic              q_empty,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output btp_pkg::result_t  result
);

  logic            ent_valid;
  btp_pkg::entry_t ent;
  logic            part;
  logic            taken;
  logic            step_tail;

  assign empty     = !ent_valid;
  assign taken     = pop && ent_valid;
  assign step_tail = taken && !part && ent.has_tail;
  assign q_rd      = !q_empty && !step_tail && (!ent_valid || taken);

  // Present primary first, then the end-of-buffer result
  always_comb begin
    result = '0;
    if (!part) begin
      result             = ent.primary;
      result.last_of_run = !ent.has_tail;
    end else begin
      result.kind        = ent.tail_err ? btp_pkg::KIND_ERR : btp_pkg::KIND_DONE;
      result.error_code  = ent.tail_err ? btp_pkg::ERR_TRUNC : 2'd0;
      result.last_of_run = 1'b1;
    end
  end

  // Hold the current entry, advance on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      part      <= 1'b0;
    end else if (step_tail) begin
      part <= 1'b1;
    end else if (q_rd) begin
      ent_valid <= 1'b1;
      part      <= !q_entry.has_primary;
    end else if (taken) begin
      ent_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      ent <= q_entry;
    end
  end

endmodule

>>> src/ber_tlv_stream_parser_top.sv
// A transferred byte's entry is written into the queue, then into the result stage register.
// Throughput: one byte per cycle while full is low; the result stage emits one result per cycle
// while pop is high, so the final byte of a buffer, which may cause two results, needs an extra pop.
// The entry queue of QUEUE_DEPTH entries absorbs stalls on the result side.
// Reset: synchronous, active high; clears decode phase, flush state, queue and result stage.
module ber_tlv_stream_parser_top #(
  parameter int MAX_LEN_OCTETS = 4,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  btp_pkg::item_t   item,
  input  logic             pop,
  output logic             empty,
  output btp_pkg::result_t result
);

  logic            accept;
  logic            wr;
  btp_pkg::entry_t wr_entry;
  btp_pkg::entry_t rd_entry;
  logic            q_rd;
  logic            q_empty;

  assign accept = push && !full;

  btp_front #(
    .MAX_LEN_OCTETS(MAX_LEN_OCTETS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (item),
    .wr    (wr),
    .entry (wr_entry)
  );

  btp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .wr_entry(wr_entry),
    .rd      (q_rd),
    .rd_entry(rd_entry),
    .full    (full),
    .empty   (q_empty)
  );

  btp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_entry(rd_entry),
    .q_empty(q_empty),
    .q_rd   (q_rd),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule
